### src/spdb_pkg.sv
// ----------------------------------------------------------------------------
// Spectrum peak statistics package
// Shared widths, register indexes, reset values and payload types.
// ----------------------------------------------------------------------------
package spdb_pkg;

	localparam int NUM_BANDS_DEF = 512;

	localparam int VAL_W      = 16;
	localparam int DECAY_W    = 16;
	localparam int SCALE_W    = 10;
	localparam int LIMIT_W    = 18;
	localparam int BCNT_W     = 10;
	localparam int AMP_W      = 19;
	localparam int CAMP_W     = 18;
	localparam int TOTAL_W    = 27;
	localparam int TALLY_W    = 10;
	localparam int BASS_W     = 24;
	localparam int ENERGY_W   = 32;
	localparam int BINC_W     = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;
	localparam int QDEPTH     = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DECAY     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BASS_CNT  = 3'd4;

	localparam logic [DECAY_W-1:0] DECAY_RST     = 16'd62915;
	localparam logic [SCALE_W-1:0] SCALE_RST     = 10'd200;
	localparam logic [LIMIT_W-1:0] LIMIT_RST     = 18'd128000;
	localparam logic [LIMIT_W-1:0] THRESHOLD_RST = 18'd2560;
	localparam logic [BCNT_W-1:0]  BASS_CNT_RST  = 10'd10;

	typedef struct packed {
		logic [VAL_W-1:0] band_value;
		logic             last_band;
	} item_t;

	typedef struct packed {
		logic [CAMP_W-1:0]   peak_amplitude;
		logic [CAMP_W-1:0]   mean_amplitude;
		logic [CAMP_W-1:0]   mean_high_amplitude;
		logic [AMP_W-1:0]    peak_high_amplitude;
		logic [ENERGY_W-1:0] bass_energy;
		logic [TALLY_W-1:0]  useful_count;
	} result_t;

	typedef struct packed {
		logic [DECAY_W-1:0] decay_factor;
		logic [SCALE_W-1:0] band_scale;
		logic [LIMIT_W-1:0] amplitude_limit;
		logic [LIMIT_W-1:0] useful_threshold;
		logic [BCNT_W-1:0]  bass_band_count;
	} cfg_t;

	typedef struct packed {
		logic [BASS_W-1:0]  bass_sum;
		logic [CAMP_W-1:0]  overall_max;
		logic [AMP_W-1:0]   high_max;
		logic [TOTAL_W-1:0] useful_total;
		logic [TOTAL_W-1:0] high_total;
		logic [TALLY_W-1:0] useful_tally;
		logic [TALLY_W-1:0] high_tally;
	} snap_t;

	// Floor of amp / 5120: a shift by 1024, then a divide by five done as a
	// multiply by 205 / 1024, which is exact for values below 1024.
	function automatic logic [BINC_W-1:0] bass_step(input logic [AMP_W-1:0] amp);
		logic [8:0]  hi;
		logic [16:0] prod;
		hi = amp[AMP_W-1:10];
		prod = 17'(hi) * 17'd205;
		return prod[16:10];
	endfunction

endpackage

### src/spdb_front.sv
// ----------------------------------------------------------------------------
// Spectrum peak statistics front end
// Holds the band peaks, applies decay and peak hold, and accumulates the
// frame statistics; pushes a snapshot of them at the end of each frame.
// ----------------------------------------------------------------------------
module spdb_front #(
	parameter int NUM_BANDS = spdb_pkg::NUM_BANDS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  spdb_pkg::cfg_t  cfg,
	input  logic            push,
	input  spdb_pkg::item_t item,
	output logic            full,
	output logic            q_push,
	output spdb_pkg::snap_t q_data,
	input  logic            q_full
);
	import spdb_pkg::*;

	localparam int AW = $clog2(NUM_BANDS);
	localparam int CW = $clog2(NUM_BANDS + 1);
	localparam int IW = (CW > BCNT_W) ? CW : BCNT_W;

	localparam logic [2:0] F_CLR  = 3'd0;
	localparam logic [2:0] F_IDLE = 3'd1;
	localparam logic [2:0] F_DEC  = 3'd2;
	localparam logic [2:0] F_AMP  = 3'd3;
	localparam logic [2:0] F_ACC  = 3'd4;

	logic [2:0]         state_q;
	logic [VAL_W-1:0]   peak_mem [NUM_BANDS];
	logic [VAL_W-1:0]   rd_q;
	logic [VAL_W-1:0]   dec_q;
	logic [VAL_W-1:0]   val_q;
	logic [AMP_W-1:0]   amp_q;
	logic               last_q;
	logic               inr_q;
	logic               bass_q;
	logic [AW-1:0]      addr_q;
	logic [AW-1:0]      clr_addr_q;
	logic [CW-1:0]      cnt_q;
	snap_t              acc_q;
	snap_t              nxt;

	logic               accept;
	logic               in_range;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic [VAL_W-1:0]   mem_wd;
	logic [VAL_W-1:0]   pk;
	logic [31:0]        dec_prod;
	logic [25:0]        amp_prod;
	logic [CAMP_W-1:0]  clamped;
	logic [BASS_W:0]    bass_add;
	logic [TOTAL_W:0]   useful_add;
	logic [TOTAL_W:0]   high_add;

	assign full     = (state_q != F_IDLE) || q_full;
	assign accept   = push && !full;
	assign in_range = cnt_q < CW'(NUM_BANDS);

	assign dec_prod = 32'(rd_q) * 32'(cfg.decay_factor);
	assign pk       = (dec_q > val_q) ? dec_q : val_q;
	assign amp_prod = 26'(pk) * 26'(cfg.band_scale);

	assign mem_we = (state_q == F_CLR) || ((state_q == F_AMP) && inr_q);
	assign mem_wa = (state_q == F_CLR) ? clr_addr_q : addr_q;
	assign mem_wd = (state_q == F_CLR) ? '0 : pk;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			peak_mem[mem_wa] <= mem_wd;
		end
		if (accept && in_range) begin
			rd_q <= peak_mem[cnt_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q  <= item.band_value;
			addr_q <= cnt_q[AW-1:0];
		end
		if (state_q == F_DEC) begin
			dec_q <= dec_prod[31:16];
		end
		if (state_q == F_AMP) begin
			amp_q <= amp_prod[25:7];
		end
	end

	assign clamped = (amp_q < AMP_W'(cfg.amplitude_limit)) ? amp_q[CAMP_W-1:0]
		: cfg.amplitude_limit;
	assign bass_add   = {1'b0, acc_q.bass_sum} + (BASS_W + 1)'(bass_step(amp_q));
	assign useful_add = {1'b0, acc_q.useful_total} + (TOTAL_W + 1)'(clamped);
	assign high_add   = {1'b0, acc_q.high_total} + (TOTAL_W + 1)'(clamped);

	always_comb begin
		nxt = acc_q;
		if (inr_q) begin
			if (bass_q) begin
				nxt.bass_sum = bass_add[BASS_W] ? '1 : bass_add[BASS_W-1:0];
			end else if (amp_q > acc_q.high_max) begin
				nxt.high_max = amp_q;
			end
			if (clamped > acc_q.overall_max) begin
				nxt.overall_max = clamped;
			end
			if (clamped > cfg.useful_threshold) begin
				if (!bass_q) begin
					nxt.high_total = high_add[TOTAL_W] ? '1 : high_add[TOTAL_W-1:0];
					if (acc_q.high_tally != '1) begin
						nxt.high_tally = acc_q.high_tally + 1'b1;
					end
				end
				nxt.useful_total = useful_add[TOTAL_W] ? '1 : useful_add[TOTAL_W-1:0];
				if (acc_q.useful_tally != '1) begin
					nxt.useful_tally = acc_q.useful_tally + 1'b1;
				end
			end
		end
	end

	assign q_push = (state_q == F_ACC) && last_q;
	assign q_data = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_CLR;
			clr_addr_q <= '0;
			cnt_q      <= '0;
			acc_q      <= '0;
			last_q     <= 1'b0;
			inr_q      <= 1'b0;
			bass_q     <= 1'b0;
		end else begin
			case (state_q)
				F_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(NUM_BANDS - 1)) begin
						state_q <= F_IDLE;
					end
				end
				F_IDLE: begin
					if (accept) begin
						last_q  <= item.last_band;
						inr_q   <= in_range;
						bass_q  <= IW'(cnt_q) < IW'(cfg.bass_band_count);
						state_q <= F_DEC;
					end
				end
				F_DEC: begin
					state_q <= F_AMP;
				end
				F_AMP: begin
					state_q <= F_ACC;
				end
				F_ACC: begin
					if (last_q) begin
						acc_q <= '0;
						cnt_q <= '0;
					end else begin
						acc_q <= nxt;
						cnt_q <= cnt_q + CW'(inr_q);
					end
					state_q <= F_IDLE;
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

### src/spdb_fifo.sv
// ----------------------------------------------------------------------------
// Spectrum peak statistics snapshot queue
// Two-entry queue of frame snapshots between the front end and the back end.
// ----------------------------------------------------------------------------
module spdb_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  spdb_pkg::snap_t wdata,
	output logic            full,
	input  logic            rd,
	output spdb_pkg::snap_t rdata,
	output logic            empty
);
	import spdb_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	snap_t         ent_q [QDEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW:0]   cnt_q;

	assign full  = cnt_q == (PW + 1)'(QDEPTH);
	assign empty = cnt_q == '0;
	assign rdata = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) begin
			ent_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr && !full) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd && !empty) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW + 1)'(wr && !full) - (PW + 1)'(rd && !empty);
		end
	end

endmodule

### src/spdb_div.sv
// ----------------------------------------------------------------------------
// Spectrum peak statistics divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spdb_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [spdb_pkg::TOTAL_W-1:0]  dividend,
	input  logic [spdb_pkg::TALLY_W-1:0]  divisor,
	output logic                          done,
	output logic [spdb_pkg::TOTAL_W-1:0]  quotient
);
	import spdb_pkg::*;

	localparam int SW = $clog2(TOTAL_W + 1);

	logic               busy_q;
	logic               done_q;
	logic [SW-1:0]      step_q;
	logic [TOTAL_W-1:0] dvd_q;
	logic [TALLY_W-1:0] rem_q;
	logic [TALLY_W-1:0] dvs_q;
	logic [TALLY_W:0]   trial;
	logic [TALLY_W:0]   diff;
	logic               ge;

	assign trial    = {rem_q, dvd_q[TOTAL_W-1]};
	assign diff     = trial - {1'b0, dvs_q};
	assign ge       = trial >= {1'b0, dvs_q};
	assign done     = done_q;
	assign quotient = dvd_q;

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[TALLY_W-1:0] : trial[TALLY_W-1:0];
			dvd_q <= {dvd_q[TOTAL_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= SW'(TOTAL_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == SW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

### src/spdb_back.sv
// ----------------------------------------------------------------------------
// Spectrum peak statistics back end
// Turns a frame snapshot into the frame result: two means by division and
// the saturated square of the bass level; holds the result until popped.
// ----------------------------------------------------------------------------
module spdb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  spdb_pkg::snap_t   q_data,
	output logic              q_pop,
	output logic              empty,
	input  logic              pop,
	output spdb_pkg::result_t result
);
	import spdb_pkg::*;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_DIV1 = 2'd1;
	localparam logic [1:0] B_DIV2 = 2'd2;
	localparam logic [1:0] B_OUT  = 2'd3;

	logic [1:0]            state_q;
	snap_t                 snap_q;
	logic [CAMP_W-1:0]     mean_q;
	logic [CAMP_W-1:0]     mean_high_q;
	logic [2*BASS_W-1:0]   sq_q;
	result_t               res_q;
	logic                  res_vld_q;

	logic                  div_start;
	logic [TOTAL_W-1:0]    div_dividend;
	logic [TALLY_W-1:0]    div_divisor;
	logic                  div_done;
	logic [TOTAL_W-1:0]    div_quo;

	assign q_pop        = (state_q == B_IDLE) && !q_empty;
	assign div_start    = q_pop || ((state_q == B_DIV1) && div_done);
	assign div_dividend = (state_q == B_IDLE) ? q_data.useful_total : snap_q.high_total;
	assign div_divisor  = (state_q == B_IDLE) ? q_data.useful_tally : snap_q.high_tally;

	spdb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign empty  = !res_vld_q;
	assign result = res_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			snap_q <= q_data;
		end
		if (state_q == B_DIV1) begin
			sq_q <= (2 * BASS_W)'(snap_q.bass_sum) * (2 * BASS_W)'(snap_q.bass_sum);
			if (div_done) begin
				mean_q <= (snap_q.useful_tally == '0) ? '0 : div_quo[CAMP_W-1:0];
			end
		end
		if ((state_q == B_DIV2) && div_done) begin
			mean_high_q <= (snap_q.high_tally == '0) ? '0 : div_quo[CAMP_W-1:0];
		end
		if ((state_q == B_OUT) && (!res_vld_q || pop)) begin
			res_q.peak_amplitude      <= snap_q.overall_max;
			res_q.mean_amplitude      <= mean_q;
			res_q.mean_high_amplitude <= mean_high_q;
			res_q.peak_high_amplitude <= snap_q.high_max;
			res_q.bass_energy         <= (sq_q[2*BASS_W-1:ENERGY_W] != '0) ? '1
				: sq_q[ENERGY_W-1:0];
			res_q.useful_count        <= snap_q.useful_tally;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			res_vld_q <= 1'b0;
		end else begin
			if (pop && res_vld_q) begin
				res_vld_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (q_pop) begin
						state_q <= B_DIV1;
					end
				end
				B_DIV1: begin
					if (div_done) begin
						state_q <= B_DIV2;
					end
				end
				B_DIV2: begin
					if (div_done) begin
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (!res_vld_q || pop) begin
						res_vld_q <= 1'b1;
						state_q   <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

### src/spectrum_peak_decay_band_stats_top.sv
// ----------------------------------------------------------------------------
// Spectrum peak hold with decay and band statistics
// Per-band peak hold with exponential decay; emits amplitude statistics of
// each frame on the band that carries the last-band flag.
//
//   Channel   Handshake          Payload
//   input     push / full        item   (band_value, last_band)
//   result    pop / empty        result (frame statistics)
//   config    cfg_wr, cfg_addr   cfg_data
//
// The front end takes one band and no new band until it has gone through
// peak memory read, decay multiply, scale multiply with write-back, then
// accumulation. After reset, full stays high while the peak memory is
// cleared.
// Each frame end costs the back end two 27-step divisions; a two-entry
// snapshot queue lets the front end keep going, and full rises only when
// that queue is full, a band is in progress or the peak memory is cleared.
// ----------------------------------------------------------------------------
module spectrum_peak_decay_band_stats_top #(
	parameter int NUM_BANDS = spdb_pkg::NUM_BANDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  spdb_pkg::item_t                 item,
	output logic                            full,
	output logic                            empty,
	input  logic                            pop,
	output spdb_pkg::result_t               result,
	input  logic                            cfg_wr,
	input  logic [spdb_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [spdb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import spdb_pkg::*;

	cfg_t  cfg_q;
	logic  q_push;
	logic  q_full;
	logic  q_pop;
	logic  q_empty;
	snap_t q_wdata;
	snap_t q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decay_factor     <= DECAY_RST;
			cfg_q.band_scale       <= SCALE_RST;
			cfg_q.amplitude_limit  <= LIMIT_RST;
			cfg_q.useful_threshold <= THRESHOLD_RST;
			cfg_q.bass_band_count  <= BASS_CNT_RST;
		end else if (cfg_wr) begin
			case (cfg_addr)
				REG_DECAY:     cfg_q.decay_factor     <= cfg_data[DECAY_W-1:0];
				REG_SCALE:     cfg_q.band_scale       <= cfg_data[SCALE_W-1:0];
				REG_LIMIT:     cfg_q.amplitude_limit  <= cfg_data[LIMIT_W-1:0];
				REG_THRESHOLD: cfg_q.useful_threshold <= cfg_data[LIMIT_W-1:0];
				REG_BASS_CNT:  cfg_q.bass_band_count  <= cfg_data[BCNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	spdb_front #(
		.NUM_BANDS (NUM_BANDS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.push   (push),
		.item   (item),
		.full   (full),
		.q_push (q_push),
		.q_data (q_wdata),
		.q_full (q_full)
	);

	spdb_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	spdb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

### src/spdb_checker.sv
// ----------------------------------------------------------------------------
// Spectrum peak statistics port checker
// Checks the result channel and the reset behavior seen at the top ports.
// ----------------------------------------------------------------------------
module spdb_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              full,
	input logic              empty,
	input logic              pop,
	input spdb_pkg::result_t result
);
	import spdb_pkg::*;

	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> (full && empty))
		else $error("Block not stalled and empty right after reset.");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("Waiting result transaction changed or vanished.");

	a_empty_means: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.useful_count == '0)) |->
		((result.mean_amplitude == '0) && (result.mean_high_amplitude == '0)))
		else $error("Nonzero mean with no band above threshold.");

	a_peak_present: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.useful_count != '0)) |-> (result.peak_amplitude != '0))
		else $error("Zero peak with bands above threshold.");

endmodule

bind spectrum_peak_decay_band_stats_top spdb_checker u_spdb_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
